FILE: rtl/sac_pkg.sv
package sac_pkg;

	localparam int ADDR_W  = 32;
	localparam int COUNT_W = 32;
	localparam int STAMP_W = 32;

	typedef logic [ADDR_W-1:0]  addr_t;
	typedef logic [COUNT_W-1:0] count_t;
	typedef logic [STAMP_W-1:0] stamp_t;

endpackage

FILE: rtl/sac_if.sv
interface sac_req_if;
	logic                  valid;
	logic                  ready;
	sac_pkg::addr_t        address;
	logic                  write_access;

	modport source (output valid, address, write_access, input ready);
	modport sink   (input valid, address, write_access, output ready);
endinterface

interface sac_rsp_if;
	logic                  valid;
	logic                  ready;
	logic                  hit;
	logic                  prefetch_filled;
	sac_pkg::count_t       access_count;
	sac_pkg::count_t       miss_count;
	sac_pkg::count_t       read_miss_count;
	sac_pkg::count_t       write_miss_count;

	modport source (output valid, hit, prefetch_filled, access_count, miss_count,
		read_miss_count, write_miss_count, input ready);
	modport sink   (input valid, hit, prefetch_filled, access_count, miss_count,
		read_miss_count, write_miss_count, output ready);
endinterface

FILE: rtl/set_assoc_lru_cache_with_prefetch.sv
// Tag-only set-associative cache with LRU replacement and next-line prefetch.
// The req channel carries one access word (address, write_access); the rsp
// channel returns one word per access: hit, prefetch_filled and the four
// running counters (accesses, misses, read misses, write misses).
// All tag state sits in one synchronous memory, one row per set holding every
// way (valid, dirty, tag, use stamp). An access walks the row through a
// read, lookup and write-back sequence.
// On a hit an access goes through read, lookup and done. A miss reads the
// prefetch set and then the access set again, with a victim scan over every
// way and a row write for each fill; when the next block is already present
// only the access set is filled. When SETS is not a power of two, the set
// index takes the extra ST_MOD state (reciprocal multiply, then subtract).
// req is ready again in the same cycle as the response is raised, so a new
// access is taken only once the previous one has finished.
// After reset a clearing pass writes every row before the
// first access is taken. If rsp stalls, a finished result waits in its
// state until the previous word is taken, and no new access is accepted
// meanwhile.
module set_assoc_lru_cache_with_prefetch #(
	parameter int WAYS        = 8,
	parameter int SETS        = 128,
	parameter int OFFSET_BITS = 4,
	parameter int ADDR_BITS   = 32
) (
	input  logic     clk,
	input  logic     arst_n,
	sac_req_if.sink  req,
	sac_rsp_if.source rsp
);
	import sac_pkg::*;

	localparam int TAG_W   = ADDR_BITS - OFFSET_BITS;
	localparam int SET_W   = (SETS > 1) ? $clog2(SETS) : 1;
	localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int ENT_W   = 2 + TAG_W + STAMP_W;
	localparam int ROW_W   = WAYS * ENT_W;
	localparam bit SETS_P2 = (SETS & (SETS - 1)) == 0;
	localparam int V_B     = ENT_W - 1;
	localparam int D_B     = ENT_W - 2;
	localparam int REC_SH  = TAG_W + SET_W;
	localparam int REC_W   = TAG_W + 1;
	localparam int PROD_W  = TAG_W + REC_W;
	localparam logic [REC_W-1:0] REC_MUL =
		REC_W'(((64'd1 << REC_SH) + 64'(SETS) - 64'd1) / 64'(SETS));

	typedef logic [WAYS-1:0][ENT_W-1:0] row_t;
	typedef enum logic [2:0] {ST_CLR, ST_IDLE, ST_MOD, ST_RD, ST_LK, ST_VIC, ST_WR,
		ST_DONE} state_t;
	typedef enum logic [1:0] {PH_LOOK, PH_PF, PH_FILL} phase_t;

	state_t             state_q;
	phase_t             phase_q;
	logic [SET_W-1:0]   clr_q;
	logic [TAG_W-1:0]   blk_q, nblk_q, quo_q;
	logic               wr_q;
	logic [SET_W-1:0]   set_q, nset_q;
	stamp_t             time_q, low_q;
	count_t             acc_q, miss_q, rmiss_q, wmiss_q;
	logic               hit_q, pf_q;
	row_t               row_q;
	logic [WAY_W-1:0]   w_q, best_q;

	logic [ROW_W-1:0]   mem [SETS];
	logic [ROW_W-1:0]   rdata;
	logic               we;
	logic [SET_W-1:0]   waddr, raddr;
	logic [ROW_W-1:0]   wdata;

	row_t               rrow, hrow, frow;
	logic [TAG_W-1:0]   ltag, new_blk;
	logic               match;
	logic [WAY_W-1:0]   mway;
	logic [PROD_W-1:0]  rec_prod;
	logic [TAG_W-1:0]   quo_nx;
	logic [SET_W-1:0]   set_nx;
	logic [ENT_W-1:0]   vent;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

	assign rrow = row_t'(rdata);
	assign ltag = (phase_q == PH_PF) ? nblk_q : blk_q;
	assign new_blk = TAG_W'(req.address[ADDR_BITS-1:0] >> OFFSET_BITS);

	// Lowest valid way with a matching tag wins.
	always_comb begin
		match = 1'b0;
		mway  = '0;
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (rrow[w][V_B] && rrow[w][STAMP_W +: TAG_W] == ltag) begin
				match = 1'b1;
				mway  = WAY_W'(w);
			end
		end
	end

	always_comb begin
		hrow = rrow;
		hrow[mway][STAMP_W-1:0] = time_q;
		hrow[mway][D_B] = rrow[mway][D_B] | wr_q;
		frow = row_q;
		frow[best_q] = {1'b1, (phase_q == PH_FILL) ? wr_q : 1'b0,
			(phase_q == PH_FILL) ? blk_q : nblk_q, time_q};
	end

	assign vent   = row_q[w_q];
	// The quotient by SETS comes from a multiply by a rounded-up reciprocal,
	// which is exact over the whole block number range.
	assign rec_prod = PROD_W'(new_blk) * PROD_W'(REC_MUL);
	assign quo_nx   = TAG_W'(rec_prod >> REC_SH);
	assign set_nx   = SET_W'(new_blk & TAG_W'(SETS - 1));

	always_comb begin
		we    = 1'b0;
		waddr = set_q;
		wdata = ROW_W'(frow);
		raddr = (phase_q == PH_PF) ? nset_q : set_q;
		unique case (state_q)
			ST_CLR: begin
				we    = 1'b1;
				waddr = clr_q;
				wdata = '0;
			end
			ST_LK: begin
				if (phase_q == PH_LOOK && match) begin
					we    = 1'b1;
					wdata = ROW_W'(hrow);
				end
			end
			ST_WR: begin
				we    = 1'b1;
				waddr = (phase_q == PH_PF) ? nset_q : set_q;
			end
			default: ;
		endcase
	end

	assign req.ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLR;
			phase_q   <= PH_LOOK;
			clr_q     <= '0;
			time_q    <= '0;
			acc_q     <= '0;
			miss_q    <= '0;
			rmiss_q   <= '0;
			wmiss_q   <= '0;
			rsp.valid <= 1'b0;
		end else begin
			rsp.valid <= (state_q == ST_DONE) || (rsp.valid && !rsp.ready);
			unique case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == SET_W'(SETS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (req.valid) begin
						blk_q   <= new_blk;
						nblk_q  <= new_blk + 1'b1;
						quo_q   <= quo_nx;
						wr_q    <= req.write_access;
						time_q  <= time_q + 1'b1;
						acc_q   <= acc_q + 1'b1;
						hit_q   <= 1'b0;
						pf_q    <= 1'b0;
						phase_q <= PH_LOOK;
						set_q   <= set_nx;
						state_q <= SETS_P2 ? ST_RD : ST_MOD;
					end
				end
				ST_MOD: begin
					set_q   <= SET_W'(blk_q - TAG_W'(quo_q * TAG_W'(SETS)));
					state_q <= ST_RD;
				end
				ST_RD: begin
					if (phase_q == PH_LOOK) begin
						// The block after the last one wraps to set zero.
						nset_q <= (nblk_q == '0 || set_q == SET_W'(SETS - 1)) ? '0
							: set_q + 1'b1;
					end
					state_q <= ST_LK;
				end
				ST_LK: begin
					row_q  <= rrow;
					w_q    <= '0;
					best_q <= '0;
					low_q  <= '1;
					unique case (phase_q)
						PH_LOOK: begin
							if (match) begin
								hit_q   <= 1'b1;
								state_q <= ST_DONE;
							end else begin
								miss_q  <= miss_q + 1'b1;
								rmiss_q <= rmiss_q + {{(COUNT_W-1){1'b0}}, !wr_q};
								wmiss_q <= wmiss_q + {{(COUNT_W-1){1'b0}}, wr_q};
								phase_q <= PH_PF;
								state_q <= ST_RD;
							end
						end
						PH_PF: begin
							if (match) begin
								phase_q <= PH_FILL;
								state_q <= ST_RD;
							end else begin
								pf_q    <= 1'b1;
								state_q <= ST_VIC;
							end
						end
						default: begin
							state_q <= ST_VIC;
						end
					endcase
				end
				ST_VIC: begin
					// Last invalid way, else the strictly oldest stamp.
					if (!vent[V_B] || vent[STAMP_W-1:0] < low_q) begin
						best_q <= w_q;
						low_q  <= vent[STAMP_W-1:0];
					end
					w_q <= w_q + 1'b1;
					if (w_q == WAY_W'(WAYS - 1)) begin
						state_q <= ST_WR;
					end
				end
				ST_WR: begin
					if (phase_q == PH_PF) begin
						phase_q <= PH_FILL;
						state_q <= ST_RD;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!rsp.valid || rsp.ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && (!rsp.valid || rsp.ready)) begin
			rsp.hit              <= hit_q;
			rsp.prefetch_filled  <= pf_q;
			rsp.access_count     <= acc_q;
			rsp.miss_count       <= miss_q;
			rsp.read_miss_count  <= rmiss_q;
			rsp.write_miss_count <= wmiss_q;
		end
	end

endmodule

FILE: tb/set_assoc_lru_cache_with_prefetch_tb.sv
module set_assoc_lru_cache_with_prefetch_tb;
	import sac_pkg::*;

	localparam int WAYS        = 8;
	localparam int SETS        = 128;
	localparam int OFFSET_BITS = 4;
	localparam int ENTRIES     = WAYS * SETS;

	typedef struct packed {
		addr_t address;
		logic  write_access;
	} access_t;

	typedef struct packed {
		logic   hit;
		logic   prefetch_filled;
		count_t access_count;
		count_t miss_count;
		count_t read_miss_count;
		count_t write_miss_count;
	} outcome_t;

	logic clk = 1'b0;
	logic arst_n;
	sac_req_if req ();
	sac_rsp_if rsp ();

	set_assoc_lru_cache_with_prefetch #(
		.WAYS(WAYS), .SETS(SETS), .OFFSET_BITS(OFFSET_BITS), .ADDR_BITS(ADDR_W)
	) DUT (
		.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp)
	);

	// Tag state of the predicted cache.
	logic           line_valid [ENTRIES];
	logic           line_dirty [ENTRIES];
	logic [27:0]    line_tag [ENTRIES];
	stamp_t         line_stamp [ENTRIES];
	stamp_t         clock_now;
	count_t         n_access, n_miss, n_rmiss, n_wmiss;

	access_t        pending_accesses [$];
	outcome_t       expected_outcomes [$];
	int             error_count;
	int             hits_seen, prefetches_seen, words_seen;
	bit             quiet_phase;
	int             send_gap, recv_gap;

	always #10 clk = ~clk;

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("mismatch %s at word %0d: got %0h expected %0h", what, words_seen, got, want);
		error_count++;
	endtask

	function automatic int find_line(input int base, input logic [27:0] blk);
		for (int w = 0; w < WAYS; w++)
			if (line_valid[base + w] && line_tag[base + w] == blk)
				return w;
		return -1;
	endfunction

	function automatic void install_block(input int base, input logic [27:0] blk,
		input logic dirty);
		int     victim;
		stamp_t lowest;
		victim = 0;
		lowest = '1;
		for (int w = 0; w < WAYS; w++)
			if (!line_valid[base + w] || line_stamp[base + w] < lowest) begin
				victim = w;
				lowest = line_stamp[base + w];
			end
		line_valid[base + victim] = 1'b1;
		line_tag[base + victim]   = blk;
		line_stamp[base + victim] = clock_now;
		line_dirty[base + victim] = dirty;
	endfunction

	function automatic outcome_t predict_access(input access_t a);
		outcome_t    o;
		logic [27:0] blk, nblk;
		addr_t       naddr;
		int          base, nbase, w;
		o = '0;
		blk = 28'(a.address >> OFFSET_BITS);
		base = (blk % SETS) * WAYS;
		clock_now++;
		n_access++;
		w = find_line(base, blk);
		if (w >= 0) begin
			o.hit = 1'b1;
			line_stamp[base + w] = clock_now;
			if (a.write_access)
				line_dirty[base + w] = 1'b1;
		end else begin
			naddr = a.address + (32'd1 << OFFSET_BITS);
			nblk = 28'(naddr >> OFFSET_BITS);
			nbase = (nblk % SETS) * WAYS;
			n_miss++;
			if (a.write_access)
				n_wmiss++;
			else
				n_rmiss++;
			if (find_line(nbase, nblk) < 0) begin
				install_block(nbase, nblk, 1'b0);
				o.prefetch_filled = 1'b1;
			end
			install_block(base, blk, a.write_access);
		end
		o.access_count     = n_access;
		o.miss_count       = n_miss;
		o.read_miss_count  = n_rmiss;
		o.write_miss_count = n_wmiss;
		return o;
	endfunction

	// Driver: one word per handshake, with random idle bursts.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req.valid <= 1'b0;
			req.address <= '0;
			req.write_access <= 1'b0;
			send_gap <= 0;
		end else begin
			if (req.valid && req.ready) begin
				expected_outcomes = {expected_outcomes,
					predict_access({req.address, req.write_access})};
			end
			if (!req.valid || req.ready) begin
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
					req.valid <= 1'b0;
				end else if (pending_accesses.size() > 0) begin
					access_t a;
					a = pending_accesses.pop_front();
					req.valid <= 1'b1;
					req.address <= a.address;
					req.write_access <= a.write_access;
					if (!quiet_phase && $urandom_range(0, 9) == 0)
						send_gap <= $urandom_range(1, 18);
				end else begin
					req.valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: compares each accepted response word with the oldest prediction.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
			recv_gap <= 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				outcome_t want;
				words_seen++;
				if (expected_outcomes.size() == 0) begin
					report("unexpected word", 0, 0);
				end else begin
					want = expected_outcomes.pop_front();
					hits_seen += want.hit;
					prefetches_seen += want.prefetch_filled;
					if (rsp.hit !== want.hit)
						report("hit", rsp.hit, want.hit);
					if (rsp.prefetch_filled !== want.prefetch_filled)
						report("prefetch_filled", rsp.prefetch_filled, want.prefetch_filled);
					if (rsp.access_count !== want.access_count)
						report("access_count", rsp.access_count, want.access_count);
					if (rsp.miss_count !== want.miss_count)
						report("miss_count", rsp.miss_count, want.miss_count);
					if (rsp.read_miss_count !== want.read_miss_count)
						report("read_miss_count", rsp.read_miss_count, want.read_miss_count);
					if (rsp.write_miss_count !== want.write_miss_count)
						report("write_miss_count", rsp.write_miss_count,
							want.write_miss_count);
				end
			end
			if (recv_gap > 0) begin
				recv_gap <= recv_gap - 1;
				rsp.ready <= 1'b0;
			end else if (!quiet_phase && $urandom_range(0, 11) == 0) begin
				recv_gap <= $urandom_range(1, 18);
				rsp.ready <= 1'b0;
			end else begin
				rsp.ready <= 1'b1;
			end
		end
	end

	task automatic queue_access(input addr_t addr, input logic wr);
		access_t a;
		a = {addr, wr};
		pending_accesses = {pending_accesses, a};
	endtask

	initial begin
		addr_t base_addr;
		int    run_len;
		arst_n = 1'b0;
		error_count = 0;
		hits_seen = 0;
		prefetches_seen = 0;
		words_seen = 0;
		quiet_phase = 1'b0;
		clock_now = '0;
		n_access = '0;
		n_miss = '0;
		n_rmiss = '0;
		n_wmiss = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			line_valid[i] = 1'b0;
			line_dirty[i] = 1'b0;
			line_tag[i] = '0;
			line_stamp[i] = '0;
		end

		// Directed: extremes, hits after miss, a prefetch that wraps the address
		// space, a prefetch hit, and one set filled past its associativity.
		queue_access(32'h0000_0000, 1'b0);
		queue_access(32'h0000_0003, 1'b1);
		queue_access(32'h0000_0010, 1'b0);
		queue_access(32'hFFFF_FFFF, 1'b1);
		queue_access(32'h0000_0000, 1'b1);
		queue_access(32'hFFFF_FFF0, 1'b0);
		queue_access(32'hAAAA_AAAA, 1'b0);
		queue_access(32'h5555_5555, 1'b1);
		for (int k = 0; k < 10; k++)
			queue_access(addr_t'(32'h0000_0500 + k * SETS * 16), k[0]);
		queue_access(32'h0000_0500, 1'b0);
		queue_access(addr_t'(32'h0000_0500 + 9 * SETS * 16), 1'b1);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Random: mostly sequential runs and a small hot region, some noise.
		while (pending_accesses.size() + words_seen < 1650 + 20) begin
			case ($urandom_range(0, 3))
				0: begin
					base_addr = $urandom;
					run_len = $urandom_range(2, 12);
					for (int k = 0; k < run_len; k++)
						queue_access(addr_t'(base_addr + k * 16), 1'($urandom_range(0, 1)));
				end
				1, 2: queue_access(addr_t'($urandom_range(0, 15) << 13)
					| addr_t'($urandom_range(0, 'h1FFF)), 1'($urandom_range(0, 1)));
				default: queue_access(addr_t'($urandom), 1'($urandom_range(0, 1)));
			endcase
			if (pending_accesses.size() > 1680)
				break;
		end
		wait (pending_accesses.size() < 200);
		quiet_phase = 1'b1;
		wait (pending_accesses.size() == 0 && !req.valid);
		wait (expected_outcomes.size() == 0);
		repeat (60) @(posedge clk);
		$display("covered %0d accesses: %0d hits, %0d prefetch fills", words_seen, hits_seen,
			prefetches_seen);
		if (error_count == 0 && expected_outcomes.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		#20000000;
		$display("timeout with %0d words outstanding", expected_outcomes.size());
		$display("DONE: errors detected");
		$finish;
	end

endmodule
